// ===== design/assert_macros.svh =====
// Assertion helpers shared by the denoise filter RTL.
// All assume a clock named i_clk and an active-low reset named i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define TWMD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define TWMD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/twmd_pkg.sv =====
// ----------------------------------------------------------------------------
// twmd_pkg
// Shared types and constants for the threshold window mean denoise filter.
// ----------------------------------------------------------------------------
package twmd_pkg;

    localparam int PIX_W   = 16;
    localparam int RAD_W   = 3;
    localparam int DIM_W   = 13;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;
    // 15x15 window plus two extra centre weights: sum below 2^24
    localparam int SUM_W   = 24;
    localparam int CNT_W   = 8;
    // rounded mean: (2*sum + cnt) / (2*cnt)
    localparam int DIV_N_W = SUM_W + 1;
    localparam int DIV_D_W = CNT_W + 1;

    localparam int DEF_MAX_RADIUS = 7;
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_PIXEL_BITS = 16;
    localparam int MAX_HEIGHT     = 4096;

    localparam logic [CFG_W-1:0] RST_THRESHOLD = 16'd10;
    localparam logic [RAD_W-1:0] RST_RADIUS    = 3'd1;
    localparam logic [DIM_W-1:0] RST_WIDTH     = 13'd1920;
    localparam logic [DIM_W-1:0] RST_HEIGHT    = 13'd1080;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [IDX_W-1:0] REG_RADIUS    = 3'd1;
    localparam logic [IDX_W-1:0] REG_WIDTH     = 3'd2;
    localparam logic [IDX_W-1:0] REG_HEIGHT    = 3'd3;
    localparam logic [IDX_W-1:0] REG_WIDE      = 3'd4;

    // One stage of the divider chain
    typedef struct packed {
        logic               vld;
        logic [DIV_D_W-1:0] rem;
        logic [DIV_N_W-1:0] num;
        logic [DIV_N_W-1:0] quo;
        logic [DIV_D_W-1:0] den;
    } t_div;

endpackage

// ===== design/twmd_div_cell.sv =====
// ----------------------------------------------------------------------------
// twmd_div_cell
// One restoring division step: shifts in one dividend bit, subtracts the
// divisor if it fits, and hands the result to the next cell.
// ----------------------------------------------------------------------------
module twmd_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  twmd_pkg::t_div i_stage,
    output twmd_pkg::t_div o_stage
);
    import twmd_pkg::*;

    logic [DIV_D_W:0]   trial;
    logic [DIV_D_W:0]   diff;
    logic               fits;
    logic               r_vld;
    logic [DIV_D_W-1:0] r_rem;
    logic [DIV_N_W-1:0] r_num;
    logic [DIV_N_W-1:0] r_quo;
    logic [DIV_D_W-1:0] r_den;

    // trial subtract
    always_comb begin
        trial = {i_stage.rem, i_stage.num[DIV_N_W-1]};
        diff  = trial - {1'b0, i_stage.den};
        fits  = (trial >= {1'b0, i_stage.den});
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_stage.vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_rem <= fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
        r_num <= {i_stage.num[DIV_N_W-2:0], 1'b0};
        r_quo <= {i_stage.quo[DIV_N_W-2:0], fits};
        r_den <= i_stage.den;
    end

    assign o_stage = {r_vld, r_rem, r_num, r_quo, r_den};

endmodule

// ===== design/twmd_div_chain.sv =====
// ----------------------------------------------------------------------------
// twmd_div_chain
// Row of division cells, one quotient bit per cell, one cell per cycle.
// ----------------------------------------------------------------------------
module twmd_div_chain (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  twmd_pkg::t_div               i_stage,
    output logic                         o_vld,
    output logic [twmd_pkg::PIX_W-1:0]   o_quo
);
    import twmd_pkg::*;

    t_div w_stage [0:DIV_N_W];

    assign w_stage[0] = i_stage;

    // cell row
    for (genvar g = 0; g < DIV_N_W; g++) begin : g_cell
        twmd_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (w_stage[g]),
            .o_stage (w_stage[g+1])
        );
    end

    // quotient fits in a pixel; keep its low bits
    assign o_vld = w_stage[DIV_N_W].vld;
    assign o_quo = w_stage[DIV_N_W].quo[PIX_W-1:0];

endmodule

// ===== design/threshold_window_mean_denoise.sv =====
// Throughput: one request in flight; a request for which an output is due
//   scans the window pixels inside the frame ((2r+1)^2 at most), divides,
//   and waits for the output register to drain before the next is accepted.
// Reset: synchronous, active low; clears positions, FSM and config to
//   defaults. The line store is not cleared.
// ----------------------------------------------------------------------------
// threshold_window_mean_denoise
// Edge-preserving window average over a raster stream with line store ring.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module threshold_window_mean_denoise #(
    parameter int MAX_RADIUS = twmd_pkg::DEF_MAX_RADIUS,
    parameter int MAX_WIDTH  = twmd_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = twmd_pkg::DEF_PIXEL_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write port
    input  logic                         i_cfg_we,
    input  logic [twmd_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [twmd_pkg::CFG_W-1:0]   i_cfg_data,
    // input stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [twmd_pkg::PIX_W-1:0]   s_axis_tdata,  // [15:0] pixel
    input  logic                         s_axis_tuser,  // [0] is_padding
    // output stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [twmd_pkg::PIX_W-1:0]   m_axis_tdata,  // [15:0] out_pixel
    output logic                         m_axis_tlast   // frame_end
);
    import twmd_pkg::*;

    localparam int RING   = 2 * MAX_RADIUS + 2;
    localparam int SLOT_W = $clog2(RING);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ADDR_W = $clog2(RING * MAX_WIDTH);
    localparam int W_W    = COL_W + 1;
    localparam logic [W_W-1:0]    MAXW      = W_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0]  MAXH      = DIM_W'(MAX_HEIGHT);
    localparam logic [RAD_W-1:0]  MAXR      = RAD_W'(MAX_RADIUS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING - 1);
    localparam logic [PIX_W-1:0]  WIDE_MASK = PIX_W'((32'd1 << PIXEL_BITS) - 1);
    localparam logic [PIX_W-1:0]  BYTE_MASK = 16'h00FF;

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_CENTRE, S_WIN, S_DRAIN, S_LAUNCH, S_DIV, S_PUSH
    } t_state;

    t_state              r_state;
    logic [CFG_W-1:0]    r_threshold;
    logic [RAD_W-1:0]    r_radius;
    logic [DIM_W-1:0]    r_fwidth;
    logic [DIM_W-1:0]    r_fheight;
    logic                r_wide;

    logic [COL_W-1:0]    r_in_col;
    logic [DIM_W-1:0]    r_in_row;
    logic [SLOT_W-1:0]   r_in_slot;
    logic [COL_W-1:0]    r_ox;
    logic [DIM_W-1:0]    r_oy;
    logic [SLOT_W-1:0]   r_out_slot;

    logic [DIM_W-1:0]    r_y;
    logic [DIM_W-1:0]    r_ry;
    logic [COL_W-1:0]    r_x;
    logic [COL_W-1:0]    r_x0;
    logic [COL_W-1:0]    r_rx;
    logic [SLOT_W-1:0]   r_yslot;

    logic [PIX_W-1:0]    r_mem [0:RING*MAX_WIDTH-1];
    logic [PIX_W-1:0]    r_rd_data;
    logic                r_rd_vld;
    logic                r_rd_c;
    logic [PIX_W-1:0]    r_centre;
    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_cnt;
    logic [PIX_W-1:0]    r_quo;
    logic                r_out_vld;
    logic [PIX_W-1:0]    r_out_pix;
    logic                r_out_last;

    logic [W_W-1:0]      eff_w;
    logic [W_W-1:0]      w_last;
    logic [DIM_W-1:0]    eff_h;
    logic [RAD_W-1:0]    eff_r;
    logic [PIX_W-1:0]    pix_mask;
    logic                in_acc;
    logic                in_store;
    logic                out_free;
    logic                push_go;
    logic                push_last;
    logic                last_pos;
    logic                cfg_restart;

    logic [DIM_W-1:0]    oyr;
    logic [DIM_W-1:0]    ry;
    logic [DIM_W-1:0]    y0;
    logic [W_W-1:0]      oxr;
    logic [W_W-1:0]      rx_w;
    logic [COL_W-1:0]    x0;
    logic [RAD_W-1:0]    dy;
    logic [SLOT_W:0]     slot_up;
    logic [SLOT_W-1:0]   yslot0;
    logic                emit;

    logic                rd_en;
    logic                rd_c;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   wr_addr;
    logic [PIX_W-1:0]    diff;
    logic [PIX_W-1:0]    limit;
    t_div                div_in;
    logic                div_vld;
    logic [PIX_W-1:0]    div_quo;

    // effective frame geometry
    always_comb begin
        if (r_fwidth == '0) begin
            eff_w = W_W'(1);
        end else if ({1'b0, r_fwidth} > (DIM_W+1)'(MAXW)) begin
            eff_w = MAXW;
        end else begin
            eff_w = W_W'(r_fwidth);
        end
        if (r_fheight == '0) begin
            eff_h = DIM_W'(1);
        end else if (r_fheight > MAXH) begin
            eff_h = MAXH;
        end else begin
            eff_h = r_fheight;
        end
        eff_r    = (r_radius > MAXR) ? MAXR : r_radius;
        pix_mask = r_wide ? WIDE_MASK : BYTE_MASK;
        w_last   = eff_w - 1'b1;
        limit    = r_threshold - 1'b1;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_store      = in_acc && !s_axis_tuser && (r_in_row < eff_h);
    assign out_free      = !r_out_vld || m_axis_tready;
    assign push_go       = (r_state == S_PUSH) && out_free;
    assign push_last     = push_go && last_pos;
    assign last_pos      = (r_oy == eff_h - 1'b1) && (W_W'(r_ox) == w_last);
    assign cfg_restart   = i_cfg_we && (i_cfg_idx == REG_RADIUS || i_cfg_idx == REG_WIDTH
                           || i_cfg_idx == REG_HEIGHT || i_cfg_idx == REG_WIDE);

    // window bounds around the next output position
    always_comb begin
        oyr     = r_oy + DIM_W'(eff_r);
        ry      = (oyr > eff_h - 1'b1) ? eff_h - 1'b1 : oyr;
        y0      = (r_oy >= DIM_W'(eff_r)) ? r_oy - DIM_W'(eff_r) : '0;
        oxr     = W_W'(r_ox) + W_W'(eff_r);
        rx_w    = (oxr > w_last) ? w_last : oxr;
        x0      = (r_ox >= COL_W'(eff_r)) ? r_ox - COL_W'(eff_r) : '0;
        dy      = RAD_W'(r_oy - y0);
        slot_up = {1'b0, r_out_slot} + (SLOT_W+1)'(RING) - (SLOT_W+1)'(dy);
        yslot0  = (r_out_slot >= SLOT_W'(dy)) ? r_out_slot - SLOT_W'(dy)
                                              : slot_up[SLOT_W-1:0];
        emit    = (r_in_row > ry) || ((r_in_row == ry) && (W_W'(r_in_col) > rx_w));
    end

    // line store addressing
    always_comb begin
        rd_en   = (r_state == S_CENTRE) || (r_state == S_WIN);
        rd_c    = (r_state == S_CENTRE);
        if (r_state == S_CENTRE) begin
            rd_addr = ADDR_W'(r_out_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(r_ox);
        end else begin
            rd_addr = ADDR_W'(r_yslot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(r_x);
        end
        wr_addr = ADDR_W'(r_in_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(r_in_col);
    end

    // line store ring
    always_ff @(posedge i_clk) begin
        if (in_store) begin
            r_mem[wr_addr] <= s_axis_tdata & pix_mask;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // window accumulator: centre first, then every window pixel close enough to it
    assign diff = (r_rd_data > r_centre) ? r_rd_data - r_centre : r_centre - r_rd_data;

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            if (r_rd_c) begin
                r_centre <= r_rd_data;
                r_sum    <= {r_rd_data, 1'b0};
                r_cnt    <= CNT_W'(2);
            end else if (diff <= limit) begin
                r_sum    <= r_sum + SUM_W'(r_rd_data);
                r_cnt    <= r_cnt + 1'b1;
            end
        end
    end

    // rounded mean by the divider chain
    always_comb begin
        div_in.vld = (r_state == S_LAUNCH);
        div_in.rem = '0;
        div_in.num = {r_sum, 1'b0} + DIV_N_W'(r_cnt);
        div_in.quo = '0;
        div_in.den = {r_cnt, 1'b0};
    end

    twmd_div_chain u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (div_in),
        .o_vld   (div_vld),
        .o_quo   (div_quo)
    );

    // input and output positions; a frame end, a geometry change or a pixel width change restarts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_restart || push_last) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_slot  <= '0;
            r_ox       <= '0;
            r_oy       <= '0;
            r_out_slot <= '0;
        end else begin
            if (in_store) begin
                if (W_W'(r_in_col) == w_last) begin
                    r_in_col  <= '0;
                    r_in_row  <= r_in_row + 1'b1;
                    r_in_slot <= (r_in_slot == LAST_SLOT) ? '0 : r_in_slot + 1'b1;
                end else begin
                    r_in_col  <= r_in_col + 1'b1;
                end
            end
            if (push_go) begin
                if (W_W'(r_ox) == w_last) begin
                    r_ox       <= '0;
                    r_oy       <= r_oy + 1'b1;
                    r_out_slot <= (r_out_slot == LAST_SLOT) ? '0 : r_out_slot + 1'b1;
                end else begin
                    r_ox       <= r_ox + 1'b1;
                end
            end
        end
    end

    // control: config, scan sequencer, output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_threshold <= RST_THRESHOLD;
            r_radius    <= RST_RADIUS;
            r_fwidth    <= RST_WIDTH;
            r_fheight   <= RST_HEIGHT;
            r_wide      <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_rd_c      <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_rd_vld <= rd_en;
            r_rd_c   <= rd_c;
            if (push_go) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end

            // register writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_THRESHOLD: r_threshold <= i_cfg_data;
                    REG_RADIUS:    r_radius    <= i_cfg_data[RAD_W-1:0];
                    REG_WIDTH:     r_fwidth    <= i_cfg_data[DIM_W-1:0];
                    REG_HEIGHT:    r_fheight   <= i_cfg_data[DIM_W-1:0];
                    REG_WIDE:      r_wide      <= i_cfg_data[0];
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_ry    <= ry;
                    r_rx    <= rx_w[COL_W-1:0];
                    r_x0    <= x0;
                    r_x     <= x0;
                    r_y     <= y0;
                    r_yslot <= yslot0;
                    r_state <= emit ? S_CENTRE : S_IDLE;
                end
                S_CENTRE: begin
                    r_state <= S_WIN;
                end
                S_WIN: begin
                    if (r_x == r_rx) begin
                        r_x <= r_x0;
                        if (r_y == r_ry) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_y     <= r_y + 1'b1;
                            r_yslot <= (r_yslot == LAST_SLOT) ? '0 : r_yslot + 1'b1;
                        end
                    end else begin
                        r_x <= r_x + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_LAUNCH;
                end
                S_LAUNCH: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_vld) begin
                        r_quo   <= div_quo;
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (out_free) begin
                        r_out_pix  <= r_quo;
                        r_out_last <= last_pos;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_pix;
    assign m_axis_tlast  = r_out_last;

    // checks
    `TWMD_ASSERT(a_in_row_bound, r_in_row <= eff_h, "input row beyond frame height")
    `TWMD_ASSERT(a_out_col_bound, W_W'(r_ox) < eff_w, "output column beyond frame width")
    `TWMD_ASSERT_IMP(a_div_owner, div_vld, r_state == S_DIV, "divider result with no owner")

endmodule
